// ===== hw/rtl/ndd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ndd_pkg;

  // Element table size and the index width it needs
  localparam int MAX_ELEMENTS = 112;
  localparam int ZI_W         = $clog2(MAX_ELEMENTS);

  // Field widths of the channels
  localparam int Z_W   = 7;
  localparam int E_W   = 32;
  localparam int M_W   = 17;
  localparam int D_W   = 16;
  localparam int EV_W  = 32;
  localparam int VAC_W = 32;
  localparam int TOT_W = 64;

  // Log domain: signed Q24
  typedef logic signed [31:0] log_t;
  localparam log_t  EIGHT_LOG = 32'sd134217728;
  localparam longint LOG_ONE  = 64'sd16777216;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  // Reciprocal of six: floor(x / 6) = (x * RECIP6) >> 34 for any 32-bit x
  localparam logic [31:0] RECIP6 = 32'hAAAA_AAAB;

  typedef log_t        exp_tab_t  [MAX_ELEMENTS];
  typedef logic [31:0] root_tab_t [25];

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  // Normalizer result: leading zero count and left-justified word
  typedef struct packed {
    logic        done;
    logic [4:0]  lz;
    logic [31:0] v;
  } norm_rsp_t;

  // Elaboration-time log2, same steps as the hardware unit
  function automatic longint c_lg2(input longint unsigned xin);
    longint unsigned x;
    longint unsigned m;
    longint          frac;
    int              n;
    x    = (xin == 0) ? 64'd1 : xin;
    n    = 63;
    frac = 0;
    while (n > 0 && x[n] == 1'b0) n--;
    if (n <= 30) m = x << (30 - n);
    else         m = x >> (n - 30);
    for (int k = 0; k < 24; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac = frac | 64'sd1;
        m    = m >> 1;
      end
    end
    return longint'(n) * LOG_ONE + frac;
  endfunction

  function automatic longint unsigned c_isqrt(input longint unsigned xin);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = xin;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Roots 2^(2^-k) in Q30
  function automatic root_tab_t c_roots();
    root_tab_t r;
    r[0] = 32'h8000_0000;
    for (int k = 1; k < 25; k++) begin
      r[k] = 32'(c_isqrt({32'd0, r[k-1]} << 30));
    end
    return r;
  endfunction

  localparam root_tab_t ROOTS = c_roots();

  localparam longint C_ED  = c_lg2(64'd192938)   - 24 * LOG_ONE;
  localparam longint C_KD  = c_lg2(64'd2243114)  - 24 * LOG_ONE;
  localparam log_t   LG_G1 = log_t'(c_lg2(64'd57055956) - 24 * LOG_ONE);
  localparam log_t   LG_G2 = log_t'(c_lg2(64'd6751823)  - 24 * LOG_ONE);

  // Per-Z exponents: log2(0.0115 * Z^-7/3) and log2(0.1337 * Z^2/3)
  function automatic exp_tab_t c_ed_tab();
    exp_tab_t t;
    longint   lz;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      lz   = c_lg2((k < 1) ? 64'd1 : 64'(k));
      t[k] = log_t'(C_ED - (7 * lz) / 3);
    end
    return t;
  endfunction

  function automatic exp_tab_t c_kd_tab();
    exp_tab_t t;
    longint   lz;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      lz   = c_lg2((k < 1) ? 64'd1 : 64'(k));
      t[k] = log_t'(C_KD + (2 * lz) / 3);
    end
    return t;
  endfunction

  localparam exp_tab_t ED_EXP = c_ed_tab();
  localparam exp_tab_t KD_EXP = c_kd_tab();

endpackage

`default_nettype wire

// ===== hw/rtl/ndd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Recoil channel
interface ndd_in_if;
  import ndd_pkg::*;
  logic             valid;
  logic             ready;
  logic [Z_W-1:0]   recoil_z;
  logic [E_W-1:0]   recoil_energy;
  logic [M_W-1:0]   recoil_mass;
  logic [D_W-1:0]   displacement_energy;

  modport source (output valid, recoil_z, recoil_energy, recoil_mass, displacement_energy,
                  input ready);
  modport sink   (input valid, recoil_z, recoil_energy, recoil_mass, displacement_energy,
                  output ready);
endinterface

// Damage result channel
interface ndd_out_if;
  import ndd_pkg::*;
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  damage_energy;
  logic [VAC_W-1:0] vacancies_added;
  logic [TOT_W-1:0] vacancy_total;

  modport source (output valid, damage_energy, vacancies_added, vacancy_total, input ready);
  modport sink   (input valid, damage_energy, vacancies_added, vacancy_total, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ndd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared 32x32 multiplier, product registered
module ndd_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= 64'(a) * 64'(b);
  end
endmodule

`default_nettype wire

// ===== hw/rtl/ndd_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Leading-zero normalizer: binary search, one shift stage per cycle
module ndd_norm (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output ndd_pkg::norm_rsp_t rsp
);
  import ndd_pkg::*;

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [31:0] v_r, v_nxt;
  logic [4:0]  lz_r, lz_nxt;
  logic [4:0]  shamt;
  logic        top_zero;

  // Shift by 16, 8, 4, 2, 1 when that many top bits are clear
  assign shamt    = 5'(5'd16 >> step_r);
  assign top_zero = (v_r >> (6'd32 - {1'b0, shamt})) == 32'd0;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    v_nxt    = v_r;
    lz_nxt   = lz_r;
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = 3'd0;
      v_nxt    = x;
      lz_nxt   = 5'd0;
    end else if (run_r) begin
      if (top_zero) begin
        v_nxt  = v_r << shamt;
        lz_nxt = lz_r + shamt;
      end
      if (step_r == 3'd4) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    v_r    <= v_nxt;
    lz_r   <= lz_nxt;
  end

  assign rsp = '{done: done_r, lz: lz_r, v: v_r};
endmodule

`default_nettype wire

// ===== hw/rtl/ndd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 64-bit restoring divider, one quotient bit per cycle
module ndd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ndd_pkg::div_req_t req,
  output ndd_pkg::div_rsp_t      rsp
);
  import ndd_pkg::*;

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [64:0] rem2;
  logic [64:0] diff;
  logic        ge;

  // Shift in next dividend bit, trial subtract
  assign rem2 = {rem_r, quo_r[63]};
  assign ge   = rem2 >= {1'b0, dsr_r};
  assign diff = rem2 - {1'b0, dsr_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = 6'd0;
      rem_nxt = 64'd0;
      quo_nxt = req.dividend;
      dsr_nxt = req.divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[63:0] : rem2[63:0];
      quo_nxt = {quo_r[62:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp = '{done: done_r, quot: quo_r};
endmodule

`default_nettype wire

// ===== hw/rtl/nrt_displacement_damage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// NRT displacement damage: one stopped recoil per input beat, one result beat out.
// The block takes log2 of energy and mass, forms the Lindhard partition in the log
// domain, evaluates three exp2 terms for the denominator, divides out the damage
// energy and applies the Kinchin-Pease vacancy rule, adding the count to a
// saturating 64-bit running total that reset clears. A recoil occupies the block
// from its accepting edge to the next accept, longer when the count needs the
// division above 2.5 Ed and shorter at zero energy, which skips the log2, exp2 and
// divide steps, plus any wait for the output register to free up. That time is
// set by the single shared 32x32 multiplier (24 squaring or root products per
// log2 or exp2, plus one reciprocal product for the divide by six) and the
// one-bit-per-cycle 64-bit divider, used at most twice per recoil.
// The result sits in an output register, so the next recoil is accepted while it
// waits to be taken.
module nrt_displacement_damage (
  input  wire logic clk,
  input  wire logic rst_n,
  ndd_in_if.sink    in_ch,
  ndd_out_if.source out_ch
);
  import ndd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LG_KICK, S_LG_NORM, S_LG_SQ, S_LG_UPD, S_LG_END,
    S_D6_KICK, S_D6_WAIT, S_EXP_INIT, S_EXP_MUL, S_EXP_UPD, S_EXP_SH,
    S_EV_KICK, S_EV_WAIT, S_VAC, S_VD_KICK, S_VD_WAIT, S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [ZI_W-1:0]   z_r, z_nxt;
  logic [E_W-1:0]    e_r, e_nxt;
  logic [M_W-1:0]    m_r, m_nxt;
  logic [D_W-1:0]    d_r, d_nxt;
  logic              lgsel_r, lgsel_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [30:0]       mant_r, mant_nxt;
  logic [23:0]       frac_r, frac_nxt;
  logic [4:0]        n_r, n_nxt;
  log_t              led_r, led_nxt;
  log_t              lk_r, lk_nxt;
  log_t              l1_r, l1_nxt;
  log_t              l2_r, l2_nxt;
  log_t              arg_r, arg_nxt;
  logic [1:0]        jsel_r, jsel_nxt;
  logic [30:0]       p_r, p_nxt;
  logic [63:0]       den_r, den_nxt;
  logic [EV_W-1:0]   ev_r, ev_nxt;
  logic [VAC_W-1:0]  vac_r, vac_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]   out_ev_r, out_ev_nxt;
  logic [VAC_W-1:0]  out_vac_r, out_vac_nxt;
  logic [TOT_W-1:0]  out_tot_r, out_tot_nxt;

  // Shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        norm_start;
  logic [31:0] norm_x;
  norm_rsp_t   norm_rsp;

  ndd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));
  ndd_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  ndd_norm u_norm (.clk(clk), .rst_n(rst_n), .start(norm_start), .x(norm_x),
                   .rsp(norm_rsp));

  // Log-domain helpers
  log_t              lg_val, lm, lm_half, led_mag_s, q6;
  logic signed [33:0] led_ext, led3, led3q;
  logic [31:0]       sq;
  logic [7:0]        zx;
  logic [7:0]        zsel;
  logic              fbit;
  logic signed [8:0] sh, nsh;
  logic [63:0]       p64, exp_val;
  logic [18:0]       d5;
  logic              ev_lt_d, ev2_ge;
  logic [64:0]       tot_sum;

  assign lg_val    = log_t'({3'b000, n_r, frac_r});
  assign lm        = lg_val - EIGHT_LOG;
  assign lm_half   = (lm + log_t'({31'd0, lm[31]})) >>> 1;
  assign led_ext   = {{2{led_r[31]}}, led_r};
  assign led3      = led_ext + (led_ext <<< 1);
  assign led3q     = (led3 + (led3[33] ? 34'sd3 : 34'sd0)) >>> 2;
  assign led_mag_s = led_r[31] ? -led_r : led_r;
  // |led| / 6 from the reciprocal product
  assign q6        = log_t'({2'b00, prod[63:34]});
  assign sq        = prod[61:30];
  assign fbit      = arg_r[5'(5'd24 - cnt_r)];

  // exp2 output scaling: mantissa shifted by floor part minus six
  assign sh  = {arg_r[31], arg_r[31:24]} - 9'sd6;
  assign nsh = -sh;
  assign p64 = {33'd0, p_r};
  always_comb begin
    if (sh > 9'sd31)            exp_val = 64'd1 << 62;
    else if (!sh[8])            exp_val = p64 << sh[4:0];
    else if (nsh >= 9'sd64)     exp_val = 64'd0;
    else                        exp_val = p64 >> nsh[5:0];
  end

  // Vacancy thresholds
  assign d5      = {1'b0, d_r, 2'b00} + 19'(d_r);
  assign ev_lt_d = ev_r < {16'd0, d_r};
  assign ev2_ge  = {ev_r, 1'b0} >= {14'd0, d5};
  assign tot_sum = {1'b0, total_r} + {25'd0, vac_r, 8'd0};

  // Z clamp
  assign zx = {1'b0, in_ch.recoil_z};
  always_comb begin
    if (zx == 8'd0)                       zsel = 8'd1;
    else if (zx >= 8'(MAX_ELEMENTS))      zsel = 8'(MAX_ELEMENTS - 1);
    else                                  zsel = zx;
  end

  // Unit operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_r)
      S_LG_SQ: begin
        mul_a = {1'b0, mant_r};
        mul_b = {1'b0, mant_r};
      end
      S_D6_KICK: begin
        mul_a = led_mag_s;
        mul_b = RECIP6;
      end
      S_EXP_MUL: begin
        mul_a = {1'b0, p_r};
        mul_b = fbit ? ROOTS[cnt_r] : Q30_ONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req = '{start: 1'b0, dividend: 64'd0, divisor: 64'd1};
    case (state_r)
      S_EV_KICK: div_req = '{start: 1'b1, dividend: {8'd0, e_r, 24'd0}, divisor: den_r};
      S_VD_KICK: div_req = '{start: 1'b1, dividend: {23'd0, ev_r, 9'd0},
                             divisor: {45'd0, d5}};
      default: ;
    endcase
  end

  assign norm_start = (state_r == S_LG_KICK);
  assign norm_x     = lgsel_r ? 32'(m_r) : e_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    z_nxt         = z_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    lgsel_nxt     = lgsel_r;
    cnt_nxt       = cnt_r;
    mant_nxt      = mant_r;
    frac_nxt      = frac_r;
    n_nxt         = n_r;
    led_nxt       = led_r;
    lk_nxt        = lk_r;
    l1_nxt        = l1_r;
    l2_nxt        = l2_r;
    arg_nxt       = arg_r;
    jsel_nxt      = jsel_r;
    p_nxt         = p_r;
    den_nxt       = den_r;
    ev_nxt        = ev_r;
    vac_nxt       = vac_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ev_nxt    = out_ev_r;
    out_vac_nxt   = out_vac_r;
    out_tot_nxt   = out_tot_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          z_nxt = ZI_W'(zsel);
          e_nxt = in_ch.recoil_energy;
          m_nxt = (in_ch.recoil_mass == '0) ? M_W'(1) : in_ch.recoil_mass;
          d_nxt = (in_ch.displacement_energy == '0) ? D_W'(1) : in_ch.displacement_energy;
          lgsel_nxt = 1'b0;
          if (in_ch.recoil_energy == '0) begin
            ev_nxt    = '0;
            state_nxt = S_VAC;
          end else begin
            state_nxt = S_LG_KICK;
          end
        end
      end
      S_LG_KICK: state_nxt = S_LG_NORM;
      S_LG_NORM: begin
        if (norm_rsp.done) begin
          n_nxt     = ~norm_rsp.lz;
          mant_nxt  = norm_rsp.v[31:1];
          frac_nxt  = 24'd0;
          cnt_nxt   = 5'd0;
          state_nxt = S_LG_SQ;
        end
      end
      S_LG_SQ: state_nxt = S_LG_UPD;
      S_LG_UPD: begin
        // Square >= 2.0 gives a one bit and halves the mantissa
        frac_nxt = {frac_r[22:0], sq[31]};
        mant_nxt = sq[31] ? sq[31:1] : sq[30:0];
        cnt_nxt  = cnt_r + 5'd1;
        state_nxt = (cnt_r == 5'd23) ? S_LG_END : S_LG_SQ;
      end
      S_LG_END: begin
        if (!lgsel_r) begin
          led_nxt   = ED_EXP[z_r] + lg_val - EIGHT_LOG;
          lgsel_nxt = 1'b1;
          state_nxt = S_LG_KICK;
        end else begin
          lk_nxt    = KD_EXP[z_r] - lm_half;
          l2_nxt    = LG_G2 + log_t'(led3q);
          state_nxt = S_D6_KICK;
        end
      end
      S_D6_KICK: state_nxt = S_D6_WAIT;
      S_D6_WAIT: begin
        // Quotient truncates toward zero
        l1_nxt    = LG_G1 + (led_r[31] ? -q6 : q6);
        jsel_nxt  = 2'd0;
        den_nxt   = 64'd1 << 24;
        state_nxt = S_EXP_INIT;
      end
      S_EXP_INIT: begin
        case (jsel_r)
          2'd0:    arg_nxt = lk_r + l1_r;
          2'd1:    arg_nxt = lk_r + l2_r;
          default: arg_nxt = lk_r + led_r;
        endcase
        p_nxt     = Q30_ONE[30:0];
        cnt_nxt   = 5'd1;
        state_nxt = S_EXP_MUL;
      end
      S_EXP_MUL: state_nxt = S_EXP_UPD;
      S_EXP_UPD: begin
        p_nxt = prod[60:30];
        if (cnt_r == 5'd24) begin
          state_nxt = S_EXP_SH;
        end else begin
          cnt_nxt   = cnt_r + 5'd1;
          state_nxt = S_EXP_MUL;
        end
      end
      S_EXP_SH: begin
        den_nxt = den_r + exp_val;
        if (jsel_r == 2'd2) begin
          state_nxt = S_EV_KICK;
        end else begin
          jsel_nxt  = jsel_r + 2'd1;
          state_nxt = S_EXP_INIT;
        end
      end
      S_EV_KICK: state_nxt = S_EV_WAIT;
      S_EV_WAIT: begin
        if (div_rsp.done) begin
          ev_nxt    = div_rsp.quot[31:0];
          state_nxt = S_VAC;
        end
      end
      S_VAC: begin
        // Kinchin-Pease: none, one, or 0.4 Ev / Ed
        if (ev_lt_d) begin
          vac_nxt   = '0;
          state_nxt = S_FIN;
        end else if (ev2_ge) begin
          state_nxt = S_VD_KICK;
        end else begin
          vac_nxt   = VAC_W'(256);
          state_nxt = S_FIN;
        end
      end
      S_VD_KICK: state_nxt = S_VD_WAIT;
      S_VD_WAIT: begin
        if (div_rsp.done) begin
          vac_nxt   = (div_rsp.quot[63:32] != 32'd0) ? '1 : div_rsp.quot[31:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ch.ready) begin
          total_nxt     = tot_sum[64] ? '1 : tot_sum[63:0];
          out_valid_nxt = 1'b1;
          out_ev_nxt    = ev_r;
          out_vac_nxt   = vac_r;
          out_tot_nxt   = tot_sum[64] ? '1 : tot_sum[63:0];
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
    end
    z_r       <= z_nxt;
    e_r       <= e_nxt;
    m_r       <= m_nxt;
    d_r       <= d_nxt;
    lgsel_r   <= lgsel_nxt;
    cnt_r     <= cnt_nxt;
    mant_r    <= mant_nxt;
    frac_r    <= frac_nxt;
    n_r       <= n_nxt;
    led_r     <= led_nxt;
    lk_r      <= lk_nxt;
    l1_r      <= l1_nxt;
    l2_r      <= l2_nxt;
    arg_r     <= arg_nxt;
    jsel_r    <= jsel_nxt;
    p_r       <= p_nxt;
    den_r     <= den_nxt;
    ev_r      <= ev_nxt;
    vac_r     <= vac_nxt;
    out_ev_r  <= out_ev_nxt;
    out_vac_r <= out_vac_nxt;
    out_tot_r <= out_tot_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.damage_energy   = out_ev_r;
  assign out_ch.vacancies_added = out_vac_r;
  assign out_ch.vacancy_total   = out_tot_r;
endmodule

`default_nettype wire

// ===== hw/rtl/ndd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_damage_energy,
  input wire logic [31:0] out_vacancies_added,
  input wire logic [63:0] out_vacancy_total
);
  // An accepted recoil keeps the block busy the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_damage_energy)
      && $stable(out_vacancies_added) && $stable(out_vacancy_total))
    else $error("result beat changed while stalled");

  // Vacancy count is zero or at least one vacancy
  a_vac_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vacancies_added == 32'd0 || out_vacancies_added >= 32'd256)
    else $error("fractional vacancy count below one");

  // A nonzero count implies a nonzero running total
  a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vacancies_added != 32'd0 |-> out_vacancy_total != 64'd0)
    else $error("running total missed a vacancy");
endmodule

bind nrt_displacement_damage ndd_checker u_ndd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_damage_energy   (out_ch.damage_energy),
  .out_vacancies_added (out_ch.vacancies_added),
  .out_vacancy_total   (out_ch.vacancy_total)
);

`default_nettype wire
